// ===== rtl/assert_macros.svh =====
// Assertion macros used by the keyed delay queue top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising clk edge outside reset.
`define KDQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define KDQ_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define KDQ_ASSERT(lbl, prop, msg)
`define KDQ_NEVER(lbl, expr, msg)
`endif

`endif

// ===== rtl/kdq_pkg.sv =====
// Types, sizes and codes of the keyed delay queue.
package kdq_pkg;

    localparam int DEPTH       = 16;
    localparam int HANDLE_BITS = 16;
    localparam int KEY_BITS    = 16;

    localparam int FIELD_W   = 16;
    localparam int HW        = (HANDLE_BITS < FIELD_W) ? HANDLE_BITS : FIELD_W;
    localparam int KW        = (KEY_BITS < FIELD_W) ? KEY_BITS : FIELD_W;
    localparam int CD_W      = 8;
    localparam int MODE_W    = 3;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int OUT_CNT_W = 5;

    // Command modes
    localparam logic [MODE_W-1:0] MODE_SCHEDULE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CANCEL   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TICK     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DRAIN    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd4;

    // Operations broadcast to every cell
    typedef logic [2:0] cell_op_t;
    localparam cell_op_t CELL_HOLD   = 3'd0;
    localparam cell_op_t CELL_KILL   = 3'd1;
    localparam cell_op_t CELL_TICK   = 3'd2;
    localparam cell_op_t CELL_CLEAR  = 3'd3;
    localparam cell_op_t CELL_MARK   = 3'd4;
    localparam cell_op_t CELL_SHIFT  = 3'd5;
    localparam cell_op_t CELL_APPEND = 3'd6;
    localparam cell_op_t CELL_POP    = 3'd7;

    typedef struct packed {
        logic [HW-1:0]   handle;
        logic [KW-1:0]   key;
        logic            key_given;
        logic [CD_W-1:0] countdown;
    } entry_t;

    typedef struct packed {
        cell_op_t      op;
        logic [KW-1:0] key;
        logic          key_given;
        entry_t        fresh;
    } cell_ctl_t;

endpackage

// ===== rtl/kdq_channels.sv =====
// Command and result channel interfaces of the keyed delay queue.
interface kdq_cmd_if import kdq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [FIELD_W-1:0]  handle;
    logic [FIELD_W-1:0]  entry_key;
    logic                key_given;
    logic [CD_W-1:0]     delay_ticks;

    modport source (output valid, mode, handle, entry_key, key_given, delay_ticks,
                    input ready);
    modport sink (input valid, mode, handle, entry_key, key_given, delay_ticks,
                  output ready);
endinterface

interface kdq_rsp_if import kdq_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 entry_valid;
    logic [FIELD_W-1:0]   out_handle;
    logic [FIELD_W-1:0]   out_key;
    logic                 out_key_given;
    logic                 last;
    logic                 key_present;
    logic [OUT_CNT_W-1:0] entry_count;
    logic                 dropped;

    modport source (output valid, entry_valid, out_handle, out_key, out_key_given, last,
                           key_present, entry_count, dropped,
                    input ready);
    modport sink (input valid, entry_valid, out_handle, out_key, out_key_given, last,
                        key_present, entry_count, dropped,
                  output ready);
endinterface

// ===== rtl/keyed_delay_queue_unit.sv =====
// Top level of the keyed delay queue: control sequencer, cell row and result register.
//
//  channel | dir | payload                                            | accepted when
//  cmd     | in  | mode, handle, entry_key, key_given, delay_ticks    | valid & ready
//  rsp     | out | entry_valid, out_handle, out_key, out_key_given,   | valid & ready
//          |     | last, key_present, entry_count, dropped            |
//
// Tick, clear and unused modes pass through the emit state to the result register.
// Schedule and cancel pass through the compact state, where entries slide left to
// close the holes left by removed entries, then through the emit state.
// Drain passes through the count states CNT_A, CNT_B and CNT_C to the drain state,
// which emits one due entry per result; after the last one the same slide closes the holes.
// Reset clears the slot valid flags, the count and the sequencer; no sweep follows.
// A stalled rsp holds the result register and the sequencer waits on it; cmd is
// taken only while the sequencer is idle.
`include "assert_macros.svh"

module keyed_delay_queue_unit import kdq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    kdq_cmd_if.sink   cmd,
    kdq_rsp_if.source rsp
);

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE    = 3'd0;
    localparam logic [ST_W-1:0] ST_COMPACT = 3'd1;
    localparam logic [ST_W-1:0] ST_EMIT    = 3'd2;
    localparam logic [ST_W-1:0] ST_CNT_A   = 3'd3;
    localparam logic [ST_W-1:0] ST_CNT_B   = 3'd4;
    localparam logic [ST_W-1:0] ST_CNT_C   = 3'd5;
    localparam logic [ST_W-1:0] ST_DRAIN   = 3'd6;

    logic [ST_W-1:0]      state_reg, state_next;
    logic [MODE_W-1:0]    mode_reg, mode_next;
    logic [HW-1:0]        handle_reg, handle_next;
    logic [KW-1:0]        key_reg, key_next;
    logic                 kg_reg, kg_next;
    logic [CD_W-1:0]      delay_reg, delay_next;
    logic                 present_reg, present_next;
    logic                 drop_reg, drop_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    logic                 ov_reg, ov_next;
    logic                 o_ev_reg, o_ev_next;
    logic [FIELD_W-1:0]   o_handle_reg, o_handle_next;
    logic [FIELD_W-1:0]   o_key_reg, o_key_next;
    logic                 o_kg_reg, o_kg_next;
    logic                 o_last_reg, o_last_next;
    logic                 o_present_reg, o_present_next;
    logic [OUT_CNT_W-1:0] o_count_reg, o_count_next;
    logic                 o_drop_reg, o_drop_next;

    cell_ctl_t            ctl;
    logic [DEPTH-1:0]     used_vec;
    logic [DEPTH-1:0]     due_vec;
    logic [DEPTH-1:0]     match_vec;
    logic [DEPTH-1:0]     first_due;
    logic [DEPTH-1:0]     left_used;
    logic [DEPTH-1:0]     right_used;
    entry_t               ent      [DEPTH];
    entry_t               right_ent[DEPTH];
    entry_t               sel_ent;
    logic [CNT_W-1:0]     bcount;
    logic [CNT_W-1:0]     cnt_total;
    logic                 packed_q;
    logic                 full;
    logic                 accept;
    logic                 slot_free;
    logic                 is_sched;

    // Row of cells with neighbor links
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign left_used[i] = 1'b1;
        end
        else
        begin : g_mid
            assign left_used[i] = used_vec[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_tail
            assign right_used[i] = 1'b0;
            assign right_ent[i]  = '0;
        end
        else
        begin : g_body
            assign right_used[i] = used_vec[i+1];
            assign right_ent[i]  = ent[i+1];
        end

        kdq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .pop_sel     (first_due[i]),
            .left_used   (left_used[i]),
            .right_used  (right_used[i]),
            .right_entry (right_ent[i]),
            .used        (used_vec[i]),
            .due         (due_vec[i]),
            .match       (match_vec[i]),
            .entry       (ent[i])
        );
    end

    kdq_count u_count (
        .clk   (clk),
        .keep  (used_vec & ~due_vec),
        .total (cnt_total)
    );

    // Queue shape: no hole below a used slot, count from the last used slot
    assign packed_q  = ~|(~used_vec[DEPTH-2:0] & used_vec[DEPTH-1:1]);
    assign full      = used_vec[DEPTH-1];
    assign first_due = due_vec & (~due_vec + DEPTH'(1));

    always_comb
    begin
        bcount = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (used_vec[i] && ((i == DEPTH - 1) || !right_used[i]))
            begin
                bcount = bcount | CNT_W'(i + 1);
            end
        end
    end

    // Select the first due entry
    always_comb
    begin
        sel_ent = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (first_due[i])
            begin
                sel_ent = sel_ent | ent[i];
            end
        end
    end

    assign cmd.ready = (state_reg == ST_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign slot_free = !ov_reg || rsp.ready;
    assign is_sched  = (mode_reg == MODE_SCHEDULE);

    // Sequencer and result loading
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        handle_next    = handle_reg;
        key_next       = key_reg;
        kg_next        = kg_reg;
        delay_next     = delay_reg;
        present_next   = present_reg;
        drop_next      = drop_reg;
        count_next     = count_reg;

        ov_next        = ov_reg && !rsp.ready;
        o_ev_next      = o_ev_reg;
        o_handle_next  = o_handle_reg;
        o_key_next     = o_key_reg;
        o_kg_next      = o_kg_reg;
        o_last_next    = o_last_reg;
        o_present_next = o_present_reg;
        o_count_next   = o_count_reg;
        o_drop_next    = o_drop_reg;

        ctl.op              = CELL_HOLD;
        ctl.key             = (state_reg == ST_IDLE) ? cmd.entry_key[KW-1:0] : key_reg;
        ctl.key_given       = (state_reg == ST_IDLE) ? cmd.key_given : kg_reg;
        ctl.fresh.handle    = handle_reg;
        ctl.fresh.key       = kg_reg ? key_reg : '0;
        ctl.fresh.key_given = kg_reg;
        ctl.fresh.countdown = delay_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next    = cmd.mode;
                    handle_next  = cmd.handle[HW-1:0];
                    key_next     = cmd.entry_key[KW-1:0];
                    kg_next      = cmd.key_given;
                    delay_next   = cmd.delay_ticks;
                    present_next = cmd.key_given && (|match_vec);
                    drop_next    = 1'b0;
                    case (cmd.mode)
                        MODE_SCHEDULE, MODE_CANCEL:
                        begin
                            ctl.op     = cmd.key_given ? CELL_KILL : CELL_HOLD;
                            state_next = ST_COMPACT;
                        end
                        MODE_TICK:
                        begin
                            ctl.op     = CELL_TICK;
                            state_next = ST_EMIT;
                        end
                        MODE_DRAIN:
                        begin
                            ctl.op     = CELL_MARK;
                            state_next = ST_CNT_A;
                        end
                        MODE_CLEAR:
                        begin
                            ctl.op     = CELL_CLEAR;
                            count_next = '0;
                            state_next = ST_EMIT;
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_COMPACT:
            begin
                // Slide entries left until the holes are closed, then append if scheduling
                if (!packed_q)
                begin
                    ctl.op = CELL_SHIFT;
                end
                else
                begin
                    if (is_sched)
                    begin
                        ctl.op = CELL_APPEND;
                    end
                    count_next = bcount + CNT_W'(is_sched && !full);
                    drop_next  = is_sched && full;
                    state_next = (mode_reg == MODE_DRAIN) ? ST_IDLE : ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    ov_next        = 1'b1;
                    o_ev_next      = 1'b0;
                    o_handle_next  = '0;
                    o_key_next     = '0;
                    o_kg_next      = 1'b0;
                    o_last_next    = 1'b1;
                    o_present_next = present_reg;
                    o_count_next   = OUT_CNT_W'(count_reg);
                    o_drop_next    = drop_reg;
                    state_next     = ST_IDLE;
                end
            end
            ST_CNT_A:
            begin
                state_next = ST_CNT_B;
            end
            ST_CNT_B:
            begin
                state_next = ST_CNT_C;
            end
            ST_CNT_C:
            begin
                count_next = cnt_total;
                state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (slot_free)
                begin
                    ov_next        = 1'b1;
                    o_present_next = present_reg;
                    o_count_next   = OUT_CNT_W'(count_reg);
                    o_drop_next    = 1'b0;
                    if (|due_vec)
                    begin
                        // Emit the first due entry and drop it from its slot
                        ctl.op        = CELL_POP;
                        o_ev_next     = 1'b1;
                        o_handle_next = FIELD_W'(sel_ent.handle);
                        o_key_next    = sel_ent.key_given ? FIELD_W'(sel_ent.key) : '0;
                        o_kg_next     = sel_ent.key_given;
                        o_last_next   = ~|(due_vec & ~first_due);
                        if (~|(due_vec & ~first_due))
                        begin
                            state_next = ST_COMPACT;
                        end
                    end
                    else
                    begin
                        o_ev_next     = 1'b0;
                        o_handle_next = '0;
                        o_key_next    = '0;
                        o_kg_next     = 1'b0;
                        o_last_next   = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        handle_reg    <= handle_next;
        key_reg       <= key_next;
        kg_reg        <= kg_next;
        delay_reg     <= delay_next;
        present_reg   <= present_next;
        drop_reg      <= drop_next;
        o_ev_reg      <= o_ev_next;
        o_handle_reg  <= o_handle_next;
        o_key_reg     <= o_key_next;
        o_kg_reg      <= o_kg_next;
        o_last_reg    <= o_last_next;
        o_present_reg <= o_present_next;
        o_count_reg   <= o_count_next;
        o_drop_reg    <= o_drop_next;
    end

    assign rsp.valid         = ov_reg;
    assign rsp.entry_valid   = o_ev_reg;
    assign rsp.out_handle    = o_handle_reg;
    assign rsp.out_key       = o_key_reg;
    assign rsp.out_key_given = o_kg_reg;
    assign rsp.last          = o_last_reg;
    assign rsp.key_present   = o_present_reg;
    assign rsp.entry_count   = o_count_reg;
    assign rsp.dropped       = o_drop_reg;

    `KDQ_ASSERT(a_idle_packed, (state_reg == ST_IDLE) |-> packed_q, "queue has holes while idle")
    `KDQ_ASSERT(a_idle_count, (state_reg == ST_IDLE) |-> (count_reg == bcount), "count disagrees with slots")
    `KDQ_NEVER(a_due_unused, |(due_vec & ~used_vec), "due flag on an empty slot")
    `KDQ_ASSERT(a_part_entry, (rsp.valid && !rsp.last) |-> rsp.entry_valid, "non-final result without entry")

endmodule

// ===== rtl/kdq_cell.sv =====
// One queue slot: holds an entry and trades it with its neighbors.
module kdq_cell import kdq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  logic      pop_sel,
    input  logic      left_used,
    input  logic      right_used,
    input  entry_t    right_entry,
    output logic      used,
    output logic      due,
    output logic      match,
    output entry_t    entry
);

    logic   used_reg, used_next;
    logic   due_reg, due_next;
    entry_t ent_reg, ent_next;

    // Compare the broadcast key against the stored one
    assign match = used_reg && ent_reg.key_given && ctl.key_given && (ent_reg.key == ctl.key);

    // Apply the broadcast operation
    always_comb
    begin
        used_next = used_reg;
        due_next  = due_reg;
        ent_next  = ent_reg;
        case (ctl.op)
            CELL_KILL:
            begin
                if (match)
                begin
                    used_next = 1'b0;
                end
            end
            CELL_TICK:
            begin
                if (ent_reg.countdown != '0)
                begin
                    ent_next.countdown = ent_reg.countdown - 1'b1;
                end
            end
            CELL_CLEAR:
            begin
                used_next = 1'b0;
                due_next  = 1'b0;
            end
            CELL_MARK:
            begin
                due_next = used_reg && (ent_reg.countdown == '0);
            end
            CELL_SHIFT:
            begin
                // Fill a hole from the right, or give the entry to a hole on the left
                if (!used_reg)
                begin
                    used_next = right_used;
                    ent_next  = right_entry;
                end
                else if (!left_used)
                begin
                    used_next = 1'b0;
                end
            end
            CELL_APPEND:
            begin
                if (!used_reg && left_used)
                begin
                    used_next = 1'b1;
                    ent_next  = ctl.fresh;
                end
            end
            CELL_POP:
            begin
                if (pop_sel)
                begin
                    used_next = 1'b0;
                    due_next  = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            due_reg  <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            due_reg  <= due_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign used  = used_reg;
    assign due   = due_reg;
    assign entry = ent_reg;

endmodule

// ===== rtl/kdq_count.sv =====
// Two-stage registered population count of the entries that stay after a drain.
module kdq_count import kdq_pkg::*;
(
    input  logic             clk,
    input  logic [DEPTH-1:0] keep,
    output logic [CNT_W-1:0] total
);

    localparam int NGRP  = (DEPTH + 7) / 8;
    localparam int GRP_W = 4;

    logic [NGRP*8-1:0]  pad;
    logic [GRP_W-1:0]   grp_next [NGRP];
    logic [GRP_W-1:0]   grp_reg  [NGRP];
    logic [CNT_W-1:0]   total_next;
    logic [CNT_W-1:0]   total_reg;

    assign pad = (NGRP*8)'(keep);

    // Count each group of eight slots
    always_comb
    begin
        logic [GRP_W-1:0] acc;
        for (int g = 0; g < NGRP; g++)
        begin
            acc = '0;
            for (int b = 0; b < 8; b++)
            begin
                acc = acc + GRP_W'(pad[g*8 + b]);
            end
            grp_next[g] = acc;
        end
    end

    // Add the group counts
    always_comb
    begin
        total_next = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            total_next = total_next + CNT_W'(grp_reg[g]);
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg   <= grp_next;
        total_reg <= total_next;
    end

    assign total = total_reg;

endmodule

// ===== tb/keyed_delay_queue_unit_test.sv =====
// Self-checking testbench for the keyed delay queue: directed table, then random bursts.
`timescale 1ns / 100ps

module keyed_delay_queue_unit_test;
    import kdq_pkg::*;

    // Mode values the block treats as no-ops
    localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

    localparam int DIRECTED_ROWS = 14;
    localparam int RANDOM_ITEMS  = 70;
    localparam int HOLD_CYCLES   = 150;
    localparam int TAIL_CYCLES   = 3 * DEPTH + 8;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int PRINT_LIMIT   = 40;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [FIELD_W-1:0] handle;
        logic [FIELD_W-1:0] entry_key;
        logic               key_given;
        logic [CD_W-1:0]    delay_ticks;
    } cmd_t;

    typedef struct packed {
        logic                 entry_valid;
        logic [FIELD_W-1:0]   out_handle;
        logic [FIELD_W-1:0]   out_key;
        logic                 out_key_given;
        logic                 last;
        logic                 key_present;
        logic [OUT_CNT_W-1:0] entry_count;
        logic                 dropped;
    } rsp_t;

    typedef struct packed {
        logic [HW-1:0]   handle;
        logic [KW-1:0]   key;
        logic            key_given;
        logic [CD_W-1:0] countdown;
    } slot_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [4:0] reps;
        logic       typed;
        rsp_t       want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    kdq_cmd_if cmd_ch ();
    kdq_rsp_if rsp_ch ();

    keyed_delay_queue_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    slot_t       queue_image[$];
    rsp_t        awaited_rsp[$];
    int unsigned mismatch_count;
    int unsigned rsp_seen;
    bit          hold_off_pending;
    dir_row_t    directed_rows [DIRECTED_ROWS];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Print one line per mismatch, up to a limit, and count every one
    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t: %s", $time, what);
    endtask

    function automatic dir_row_t mk_row(logic [MODE_W-1:0] mode, logic [FIELD_W-1:0] handle,
                                        logic [FIELD_W-1:0] entry_key, logic key_given,
                                        logic [CD_W-1:0] delay_ticks, int unsigned reps,
                                        logic typed, logic present,
                                        logic [OUT_CNT_W-1:0] count, logic dropped);
        dir_row_t r;
        r.cmd  = '{mode, handle, entry_key, key_given, delay_ticks};
        r.reps = 5'(reps);
        r.typed = typed;
        r.want = '{1'b0, '0, '0, 1'b0, 1'b1, present, count, dropped};
        return r;
    endfunction

    // Update the queue image for one command and queue the responses it causes
    task automatic advance_queue_image(input cmd_t c, input logic typed, input rsp_t typed_rsp);
        slot_t kept[$];
        slot_t due[$];
        slot_t fresh;
        rsp_t  r;
        logic  present;
        logic  dropped;
        present = 1'b0;
        dropped = 1'b0;
        if (c.key_given)
            foreach (queue_image[i])
                if (queue_image[i].key_given && queue_image[i].key == KW'(c.entry_key))
                    present = 1'b1;
        // Drop keyed matches for schedule and cancel
        if (c.key_given && (c.mode == MODE_SCHEDULE || c.mode == MODE_CANCEL))
        begin
            foreach (queue_image[i])
                if (!(queue_image[i].key_given && queue_image[i].key == KW'(c.entry_key)))
                    kept = {kept, queue_image[i]};
            queue_image = kept;
        end
        case (c.mode)
            MODE_SCHEDULE:
            begin
                if (queue_image.size() < DEPTH)
                begin
                    fresh.handle    = HW'(c.handle);
                    fresh.key       = c.key_given ? KW'(c.entry_key) : '0;
                    fresh.key_given = c.key_given;
                    fresh.countdown = c.delay_ticks;
                    queue_image     = {queue_image, fresh};
                end
                else
                    dropped = 1'b1;
            end
            MODE_TICK:
            begin
                foreach (queue_image[i])
                    if (queue_image[i].countdown != 0)
                        queue_image[i].countdown--;
            end
            MODE_DRAIN:
            begin
                kept.delete();
                foreach (queue_image[i])
                    if (queue_image[i].countdown == 0)
                        due = {due, queue_image[i]};
                    else
                        kept = {kept, queue_image[i]};
                queue_image = kept;
            end
            MODE_CLEAR:
                queue_image.delete();
            default:
                ;
        endcase
        if (typed)
        begin
            awaited_rsp = {awaited_rsp, typed_rsp};
            return;
        end
        r = '{1'b0, '0, '0, 1'b0, 1'b1, present, OUT_CNT_W'(queue_image.size()), dropped};
        if (due.size() == 0)
            awaited_rsp = {awaited_rsp, r};
        foreach (due[i])
        begin
            r.entry_valid   = 1'b1;
            r.out_handle    = FIELD_W'(due[i].handle);
            r.out_key       = due[i].key_given ? FIELD_W'(due[i].key) : '0;
            r.out_key_given = due[i].key_given;
            r.last          = (i == due.size() - 1);
            awaited_rsp     = {awaited_rsp, r};
        end
    endtask

    // Offer one transaction and hold it until the block takes it
    task automatic offer_command(input cmd_t c, input logic typed, input rsp_t typed_rsp);
        cmd_ch.valid       <= 1'b1;
        cmd_ch.mode        <= c.mode;
        cmd_ch.handle      <= c.handle;
        cmd_ch.entry_key   <= c.entry_key;
        cmd_ch.key_given   <= c.key_given;
        cmd_ch.delay_ticks <= c.delay_ticks;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        advance_queue_image(c, typed, typed_rsp);
    endtask

    task automatic sender_pause(input int unsigned cycles);
        if (cycles > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Mostly schedules and ticks over a small key set so replacement and cancel hit
    function automatic cmd_t random_command();
        cmd_t        c;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            c.mode = MODE_SCHEDULE;
        else if (pick < 55)
            c.mode = MODE_CANCEL;
        else if (pick < 72)
            c.mode = MODE_TICK;
        else if (pick < 88)
            c.mode = MODE_DRAIN;
        else if (pick < 93)
            c.mode = MODE_CLEAR;
        else
            c.mode = MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
        c.handle = FIELD_W'($urandom);
        if ($urandom_range(0, 4) == 0)
            c.entry_key = FIELD_W'($urandom);
        else
            case ($urandom_range(0, 5))
                0: c.entry_key = 16'h0000;
                1: c.entry_key = 16'h0001;
                2: c.entry_key = 16'h00ff;
                3: c.entry_key = 16'h8000;
                4: c.entry_key = 16'hffff;
                default: c.entry_key = 16'h1234;
            endcase
        c.key_given = ($urandom_range(0, 6) != 0);
        if ($urandom_range(0, 3) == 0)
            c.delay_ticks = CD_W'($urandom);
        else
            c.delay_ticks = CD_W'($urandom_range(0, 3));
        return c;
    endfunction

    task automatic compare_rsp(input rsp_t got, input rsp_t want);
        if (got.entry_valid !== want.entry_valid)
            report_mismatch($sformatf("result %0d entry_valid %b, expected %b",
                                      rsp_seen, got.entry_valid, want.entry_valid));
        if (got.out_handle !== want.out_handle)
            report_mismatch($sformatf("result %0d out_handle %h, expected %h",
                                      rsp_seen, got.out_handle, want.out_handle));
        if (got.out_key !== want.out_key)
            report_mismatch($sformatf("result %0d out_key %h, expected %h",
                                      rsp_seen, got.out_key, want.out_key));
        if (got.out_key_given !== want.out_key_given)
            report_mismatch($sformatf("result %0d out_key_given %b, expected %b",
                                      rsp_seen, got.out_key_given, want.out_key_given));
        if (got.last !== want.last)
            report_mismatch($sformatf("result %0d last %b, expected %b",
                                      rsp_seen, got.last, want.last));
        if (got.key_present !== want.key_present)
            report_mismatch($sformatf("result %0d key_present %b, expected %b",
                                      rsp_seen, got.key_present, want.key_present));
        if (got.entry_count !== want.entry_count)
            report_mismatch($sformatf("result %0d entry_count %0d, expected %0d",
                                      rsp_seen, got.entry_count, want.entry_count));
        if (got.dropped !== want.dropped)
            report_mismatch($sformatf("result %0d dropped %b, expected %b",
                                      rsp_seen, got.dropped, want.dropped));
    endtask

    // Check each accepted response transaction against the oldest expectation
    always @(posedge clk)
    begin : rsp_monitor
        rsp_t got;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            got = '{rsp_ch.entry_valid, rsp_ch.out_handle, rsp_ch.out_key,
                    rsp_ch.out_key_given, rsp_ch.last, rsp_ch.key_present,
                    rsp_ch.entry_count, rsp_ch.dropped};
            if (awaited_rsp.size() == 0)
                report_mismatch($sformatf("result %0d arrived with nothing expected", rsp_seen));
            else
                compare_rsp(got, awaited_rsp.pop_front());
            rsp_seen++;
        end
    end

    // Stall the response side in segments of varying style, with one long hold-off
    initial
    begin
        int unsigned seg_len;
        int unsigned style;
        rsp_ch.ready = 1'b0;
        forever
        begin
            seg_len = $urandom_range(4, 40);
            style   = $urandom_range(0, 3);
            if (hold_off_pending)
            begin
                hold_off_pending = 1'b0;
                @(posedge clk);
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
            begin
                for (int unsigned i = 0; i < seg_len; i++)
                begin
                    @(posedge clk);
                    case (style)
                        0: rsp_ch.ready <= 1'b1;
                        1: rsp_ch.ready <= 1'($urandom_range(0, 1));
                        2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                        default: rsp_ch.ready <= i[0];
                    endcase
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("keyed_delay_queue_unit_test failed");
        $finish;
    end

    initial
    begin
        cmd_t        c;
        int unsigned sent;
        int unsigned burst;
        int unsigned waited;
        rst_n              = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.mode        = MODE_SCHEDULE;
        cmd_ch.handle      = '0;
        cmd_ch.entry_key   = '0;
        cmd_ch.key_given   = 1'b0;
        cmd_ch.delay_ticks = '0;
        mismatch_count     = 0;
        rsp_seen           = 0;
        hold_off_pending   = 1'b0;

        // mode, handle, key, keyed, delay, repeats, typed, present, count, dropped
        directed_rows = '{
            mk_row(MODE_DRAIN,       16'h0000, 16'h0000, 1'b0, 8'd0,   1,  1'b1, 1'b0, 5'd0,  1'b0),
            mk_row(MODE_SCHEDULE,    16'hffff, 16'hffff, 1'b1, 8'd0,   1,  1'b1, 1'b0, 5'd1,  1'b0),
            mk_row(MODE_SCHEDULE,    16'h0000, 16'h0000, 1'b0, 8'd255, 1,  1'b1, 1'b0, 5'd2,  1'b0),
            mk_row(MODE_SCHEDULE,    16'h1234, 16'h0000, 1'b1, 8'd1,   1,  1'b1, 1'b0, 5'd3,  1'b0),
            mk_row(MODE_SCHEDULE,    16'haaaa, 16'hffff, 1'b1, 8'd2,   1,  1'b1, 1'b1, 5'd3,  1'b0),
            mk_row(MODE_CANCEL,      16'h0000, 16'h0000, 1'b0, 8'd0,   1,  1'b1, 1'b0, 5'd3,  1'b0),
            mk_row(MODE_SPARE_FIRST, 16'h5555, 16'hffff, 1'b1, 8'd7,   1,  1'b1, 1'b1, 5'd3,  1'b0),
            mk_row(MODE_TICK,        16'h0000, 16'h0000, 1'b0, 8'd0,   1,  1'b1, 1'b0, 5'd3,  1'b0),
            mk_row(MODE_CANCEL,      16'h0000, 16'h0000, 1'b1, 8'd0,   1,  1'b1, 1'b1, 5'd2,  1'b0),
            mk_row(MODE_SCHEDULE,    16'h5500, 16'h0100, 1'b1, 8'd0,   14, 1'b0, 1'b0, 5'd0,  1'b0),
            mk_row(MODE_SCHEDULE,    16'hbeef, 16'h0000, 1'b0, 8'd5,   1,  1'b1, 1'b0, 5'd16, 1'b1),
            mk_row(MODE_SCHEDULE,    16'hc0de, 16'h0100, 1'b1, 8'd0,   1,  1'b0, 1'b0, 5'd0,  1'b0),
            mk_row(MODE_DRAIN,       16'h0000, 16'h0000, 1'b0, 8'd0,   1,  1'b0, 1'b0, 5'd0,  1'b0),
            mk_row(MODE_CLEAR,       16'h0000, 16'h0000, 1'b0, 8'd0,   1,  1'b1, 1'b0, 5'd0,  1'b0)
        };

        // Hold reset low, then release it
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table back to back; repeated rows step handle and key
        foreach (directed_rows[r])
        begin
            for (int unsigned k = 0; k < directed_rows[r].reps; k++)
            begin
                c = directed_rows[r].cmd;
                c.handle    = c.handle + FIELD_W'(k);
                c.entry_key = c.entry_key + FIELD_W'(k);
                offer_command(c, directed_rows[r].typed, directed_rows[r].want);
            end
        end

        // Random bursts; ask the receiver for one long hold-off early on
        hold_off_pending = 1'b1;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 12);
            for (int unsigned b = 0; b < burst && sent < RANDOM_ITEMS; b++)
            begin
                c = random_command();
                offer_command(c, 1'b0, '0);
                if (c.mode <= MODE_CLEAR)
                    sent++;
            end
            sender_pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
        end
        cmd_ch.valid <= 1'b0;

        // Wait out the remaining responses, then a quiet tail
        waited = 0;
        while (awaited_rsp.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (awaited_rsp.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived", awaited_rsp.size()));

        if (mismatch_count == 0)
            $display("keyed_delay_queue_unit_test passed");
        else
            $display("keyed_delay_queue_unit_test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/kdq_pkg.sv
rtl/kdq_channels.sv
rtl/kdq_cell.sv
rtl/kdq_count.sv
rtl/keyed_delay_queue_unit.sv
tb/keyed_delay_queue_unit_test.sv
